@@ hw/rtl/thab_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// thab_pkg
// Shared types and hash constants for the three-hash address filter.
// ----------------------------------------------------------------------------
package thab_pkg;

	localparam logic [31:0] MUR_C1    = 32'h85ebca6b;
	localparam logic [31:0] MUR_C2    = 32'hc2b2ae35;
	localparam logic [31:0] FNV_OFF   = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [63:0] SM_GOLD   = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_M1     = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_M2     = 64'h94d049bb133111eb;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_CHECK  = 1'b1;

	// Eight fold steps followed by six compare and subtract steps.
	localparam logic [3:0] MOD_LAST = 4'd13;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_H4,
		ST_H5,
		ST_MLOAD,
		ST_MOD,
		ST_READ,
		ST_RMW
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic h1;
		logic h2;
		logic h3;
		logic h4;
		logic h5;
		logic mload;
		logic mstep;
		logic rd;
		logic wr;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_last;
		logic out_busy;
		logic req_check;
	} status_t;

endpackage
`default_nettype wire

@@ hw/rtl/thab_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// thab_store
// One bit store: a word memory with one write port and one registered read.
// ----------------------------------------------------------------------------
module thab_store #(
	parameter int WORDS = 16384,
	parameter int AW    = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [63:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [63:0]   rdata
);

	logic [63:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/thab_mod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// thab_mod
// Remainder unit: reduces a 64-bit hash modulo a constant. Eight steps fold
// eight bits each through a table of powers of two modulo the constant, then
// six compare and subtract steps bring the sum below the constant.
// ----------------------------------------------------------------------------
module thab_mod #(
	parameter int DIV = 1048576,
	parameter int RW  = 20
) (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire logic          step,
	input  wire logic [3:0]    idx,
	input  wire logic [63:0]   dividend,
	output logic      [RW-1:0] rem
);

	logic [63:0]   div_q;
	logic [RW+5:0] acc_q;
	logic [RW-1:0] tbl [64];
	logic [RW+5:0] part;
	logic [RW+5:0] sub;
	logic [RW+5:0] trial;

	function automatic longint pow2_mod(int n);
		longint r;
		r = 1 % DIV;
		for (int k = 0; k < n; k++) begin
			r = (r * 2) % DIV;
		end
		return r;
	endfunction

	for (genvar gi = 0; gi < 64; gi++) begin : g_tbl
		localparam logic [RW-1:0] RES = RW'(pow2_mod(gi));
		assign tbl[gi] = RES;
	end

	always_comb begin
		part = '0;
		for (int j = 0; j < 8; j++) begin
			if (div_q[j]) begin
				part = part + (RW+6)'(tbl[{idx[2:0], 3'(j)}]);
			end
		end
	end

	assign sub   = (RW+6)'(DIV) << (thab_pkg::MOD_LAST - idx);
	assign trial = acc_q - sub;

	always_ff @(posedge clk) begin
		if (load) begin
			div_q <= dividend;
			acc_q <= '0;
		end else if (step) begin
			if (!idx[3]) begin
				acc_q <= acc_q + part;
				div_q <= div_q >> 8;
			end else if (acc_q >= sub) begin
				acc_q <= trial;
			end
		end
	end

	assign rem = acc_q[RW-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/thab_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// thab_ctrl
// Sequencer: clearing, hashing, reduction, read-modify-write or result load.
// ----------------------------------------------------------------------------
module thab_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire thab_pkg::status_t sts,
	output thab_pkg::cmd_t         cmd
);

	thab_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= thab_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			thab_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = thab_pkg::ST_IDLE;
				end
			end
			thab_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = thab_pkg::ST_H1;
				end
			end
			thab_pkg::ST_H1: begin
				cmd.h1  = 1'b1;
				state_d = thab_pkg::ST_H2;
			end
			thab_pkg::ST_H2: begin
				cmd.h2  = 1'b1;
				state_d = thab_pkg::ST_H3;
			end
			thab_pkg::ST_H3: begin
				cmd.h3  = 1'b1;
				state_d = thab_pkg::ST_H4;
			end
			thab_pkg::ST_H4: begin
				cmd.h4  = 1'b1;
				state_d = thab_pkg::ST_H5;
			end
			thab_pkg::ST_H5: begin
				cmd.h5  = 1'b1;
				state_d = thab_pkg::ST_MLOAD;
			end
			thab_pkg::ST_MLOAD: begin
				cmd.mload = 1'b1;
				state_d   = thab_pkg::ST_MOD;
			end
			thab_pkg::ST_MOD: begin
				cmd.mstep = 1'b1;
				if (sts.mod_last) begin
					state_d = thab_pkg::ST_READ;
				end
			end
			thab_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = thab_pkg::ST_RMW;
			end
			thab_pkg::ST_RMW: begin
				if (!sts.req_check) begin
					cmd.wr  = 1'b1;
					state_d = thab_pkg::ST_IDLE;
				end else if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = thab_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = thab_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/thab_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// thab_dp
// Datapath: hash registers, remainder units, the three bit stores and the
// result register.
// ----------------------------------------------------------------------------
module thab_dp #(
	parameter int LOW_WORDS   = 16384,
	parameter int MID_WORDS   = 4096,
	parameter int WHOLE_WORDS = 16384
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire thab_pkg::cmd_t cmd,
	output thab_pkg::status_t   sts,
	input  wire logic [2:0]     stage_enable,
	input  wire logic           req_type,
	input  wire logic [63:0]    addr,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output logic                maybe_present
);

	localparam int MAXW0 = (LOW_WORDS > MID_WORDS) ? LOW_WORDS : MID_WORDS;
	localparam int MAXW  = (MAXW0 > WHOLE_WORDS) ? MAXW0 : WHOLE_WORDS;
	localparam int CW    = (MAXW > 1) ? $clog2(MAXW) : 1;
	localparam int LAW   = (LOW_WORDS > 1) ? $clog2(LOW_WORDS) : 1;
	localparam int MAW   = (MID_WORDS > 1) ? $clog2(MID_WORDS) : 1;
	localparam int WAW   = (WHOLE_WORDS > 1) ? $clog2(WHOLE_WORDS) : 1;
	localparam int LRW   = $clog2(LOW_WORDS * 64);
	localparam int MRW   = $clog2(MID_WORDS * 64);
	localparam int WRW   = $clog2(WHOLE_WORDS * 64);

	logic [CW-1:0] clr_q;
	logic [3:0]    cnt_q;
	logic          req_q;
	logic [63:0]   addr_q;
	logic [31:0]   lo_q;
	logic [31:0]   mid_q;
	logic [63:0]   w_q;
	logic [63:0]   pp0_q;
	logic [31:0]   pp1_q;
	logic [31:0]   pp2_q;
	logic          out_v_q;
	logic          out_b_q;

	logic [31:0] lo_x;
	logic [31:0] lo_y;
	logic [63:0] t;
	logic [63:0] m;
	logic [63:0] w_sum;

	logic [LRW-1:0] lrem;
	logic [MRW-1:0] mrem;
	logic [WRW-1:0] wrem;
	logic [63:0] lrd, mrd, wrd;
	logic [LAW-1:0] lidx;
	logic [MAW-1:0] midx;
	logic [WAW-1:0] widx;
	logic [63:0] lmask, mmask, wmask;
	logic l_we, m_we, w_we;
	logic hit;

	assign lo_x  = addr_q[31:0] ^ (addr_q[31:0] >> 16);
	assign lo_y  = lo_q ^ (lo_q >> 13);
	assign t     = cmd.h2 ? (w_q ^ (w_q >> 30)) : (w_q ^ (w_q >> 27));
	assign m     = cmd.h2 ? thab_pkg::SM_M1 : thab_pkg::SM_M2;
	assign w_sum = pp0_q + {pp1_q + pp2_q, 32'b0};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			addr_q <= addr;
		end
		if (cmd.h1) begin
			lo_q  <= lo_x * thab_pkg::MUR_C1;
			mid_q <= (addr_q[47:16] ^ thab_pkg::FNV_OFF) * thab_pkg::FNV_PRIME;
			w_q   <= addr_q + thab_pkg::SM_GOLD;
		end
		if (cmd.h2) begin
			lo_q <= lo_y * thab_pkg::MUR_C2;
		end
		if (cmd.h2 || cmd.h4) begin
			pp0_q <= {32'b0, t[31:0]} * {32'b0, m[31:0]};
			pp1_q <= t[63:32] * m[31:0];
			pp2_q <= t[31:0] * m[63:32];
		end
		if (cmd.h3) begin
			lo_q <= lo_q ^ (lo_q >> 16);
		end
		if (cmd.h3 || cmd.h5) begin
			w_q <= w_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + CW'(1);
			end
			if (cmd.mload) begin
				cnt_q <= '0;
			end else if (cmd.mstep) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (cmd.out_ld) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_b_q <= hit;
		end
	end

	thab_mod #(.DIV(LOW_WORDS * 64), .RW(LRW)) u_lmod (
		.clk(clk), .load(cmd.mload), .step(cmd.mstep), .idx(cnt_q),
		.dividend({32'b0, lo_q}), .rem(lrem)
	);
	thab_mod #(.DIV(MID_WORDS * 64), .RW(MRW)) u_mmod (
		.clk(clk), .load(cmd.mload), .step(cmd.mstep), .idx(cnt_q),
		.dividend({32'b0, mid_q}), .rem(mrem)
	);
	thab_mod #(.DIV(WHOLE_WORDS * 64), .RW(WRW)) u_wmod (
		.clk(clk), .load(cmd.mload), .step(cmd.mstep), .idx(cnt_q),
		.dividend(w_q ^ (w_q >> 31)), .rem(wrem)
	);

	assign lidx  = LAW'(lrem >> 6);
	assign midx  = MAW'(mrem >> 6);
	assign widx  = WAW'(wrem >> 6);
	assign lmask = 64'd1 << lrem[5:0];
	assign mmask = 64'd1 << mrem[5:0];
	assign wmask = 64'd1 << wrem[5:0];

	assign l_we = cmd.wr || (cmd.clr && (32'(clr_q) < 32'(LOW_WORDS)));
	assign m_we = cmd.wr || (cmd.clr && (32'(clr_q) < 32'(MID_WORDS)));
	assign w_we = cmd.wr || (cmd.clr && (32'(clr_q) < 32'(WHOLE_WORDS)));

	thab_store #(.WORDS(LOW_WORDS), .AW(LAW)) u_lstore (
		.clk(clk), .we(l_we),
		.waddr(cmd.clr ? LAW'(clr_q) : lidx),
		.wdata(cmd.clr ? 64'd0 : (lrd | lmask)),
		.re(cmd.rd), .raddr(lidx), .rdata(lrd)
	);
	thab_store #(.WORDS(MID_WORDS), .AW(MAW)) u_mstore (
		.clk(clk), .we(m_we),
		.waddr(cmd.clr ? MAW'(clr_q) : midx),
		.wdata(cmd.clr ? 64'd0 : (mrd | mmask)),
		.re(cmd.rd), .raddr(midx), .rdata(mrd)
	);
	thab_store #(.WORDS(WHOLE_WORDS), .AW(WAW)) u_wstore (
		.clk(clk), .we(w_we),
		.waddr(cmd.clr ? WAW'(clr_q) : widx),
		.wdata(cmd.clr ? 64'd0 : (wrd | wmask)),
		.re(cmd.rd), .raddr(widx), .rdata(wrd)
	);

	assign hit = (!stage_enable[0] || ((lrd & lmask) != 64'd0))
		&& (!stage_enable[1] || ((mrd & mmask) != 64'd0))
		&& (!stage_enable[2] || ((wrd & wmask) != 64'd0));

	assign sts.clr_last  = (32'(clr_q) == 32'(MAXW - 1));
	assign sts.mod_last  = (cnt_q == thab_pkg::MOD_LAST);
	assign sts.out_busy  = out_v_q && rsp_stall;
	assign sts.req_check = (req_q == thab_pkg::REQ_CHECK);

	assign rsp_valid     = out_v_q;
	assign maybe_present = out_b_q;

endmodule
`default_nettype wire

@@ hw/rtl/three_hash_address_bloom_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// three_hash_address_bloom_filter
// Membership filter for 64-bit addresses over three hashed bit stores.
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_type, addr
// rsp       out        rsp_valid / rsp_stall  maybe_present
// cfg       in         APB psel/penable       stage_enable at byte addresses 0-3
//
// A transaction passes through the hash steps, the 14-step remainder reduction
// of the hashes, a store read and a write-back or result load before the next.
// After reset the stores are cleared word by word, during which req_stall is
// high.
// A check whose result finds the output register still stalled waits there.
// ----------------------------------------------------------------------------
module three_hash_address_bloom_filter #(
	parameter int LOW_WORDS   = 16384,
	parameter int MID_WORDS   = 4096,
	parameter int WHOLE_WORDS = 16384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        req_type,
	input  wire logic [63:0] addr,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             maybe_present
);

	logic [2:0]        stage_enable_q;
	thab_pkg::cmd_t    cmd;
	thab_pkg::status_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_enable_q <= 3'd7;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			stage_enable_q <= pwdata[2:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {29'b0, stage_enable_q};

	thab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.sts(sts), .cmd(cmd)
	);

	thab_dp #(
		.LOW_WORDS(LOW_WORDS), .MID_WORDS(MID_WORDS), .WHOLE_WORDS(WHOLE_WORDS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.stage_enable(stage_enable_q),
		.req_type(req_type), .addr(addr),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.maybe_present(maybe_present)
	);

endmodule
`default_nettype wire

@@ bench/bloom_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bloom_checker
// Watches the request and response channels of the three-hash address
// filter, keeps its own copy of the three bit stores and the stage enable,
// predicts the membership answer of every check and compares it.
// ----------------------------------------------------------------------------
module bloom_checker #(
	parameter int LOW_WORDS   = 16384,
	parameter int MID_WORDS   = 4096,
	parameter int WHOLE_WORDS = 16384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  wire logic        req_type,
	input  wire logic [63:0] addr,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire logic        maybe_present,
	output int               errors,
	output int               pending
);

	localparam logic [2:0] ADDR_STAGE_ENABLE = 3'd0;

	bit   low_bits   [LOW_WORDS*64];
	bit   mid_bits   [MID_WORDS*64];
	bit   whole_bits [WHOLE_WORDS*64];
	logic [2:0] enable_mask;
	logic answers_due [$];

	function automatic logic [31:0] murmur_fmix(logic [63:0] a);
		logic [31:0] x;
		x = a[31:0];
		x = x ^ (x >> 16);
		x = x * thab_pkg::MUR_C1;
		x = x ^ (x >> 13);
		x = x * thab_pkg::MUR_C2;
		return x ^ (x >> 16);
	endfunction

	function automatic logic [31:0] fnv_round(logic [63:0] a);
		logic [31:0] h;
		h = thab_pkg::FNV_OFF ^ a[47:16];
		return h * thab_pkg::FNV_PRIME;
	endfunction

	function automatic logic [63:0] splitmix_fmix(logic [63:0] a);
		logic [63:0] h;
		h = a + thab_pkg::SM_GOLD;
		h = (h ^ (h >> 30)) * thab_pkg::SM_M1;
		h = (h ^ (h >> 27)) * thab_pkg::SM_M2;
		return h ^ (h >> 31);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] pl, pm, pw;
		logic hit;
		logic want;
		if (!arst_n) begin
			foreach (low_bits[i]) low_bits[i] = 0;
			foreach (mid_bits[i]) mid_bits[i] = 0;
			foreach (whole_bits[i]) whole_bits[i] = 0;
			enable_mask = 3'b111;
			answers_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_STAGE_ENABLE)
				enable_mask = pwdata[2:0];
			if (req_valid && !req_stall) begin
				pl = 64'(murmur_fmix(addr)) % (LOW_WORDS * 64);
				pm = 64'(fnv_round(addr)) % (MID_WORDS * 64);
				pw = splitmix_fmix(addr) % (64'(WHOLE_WORDS) * 64);
				if (req_type == thab_pkg::REQ_INSERT) begin
					low_bits[pl] = 1;
					mid_bits[pm] = 1;
					whole_bits[pw] = 1;
				end else begin
					hit = 1;
					if (enable_mask[0] && !low_bits[pl]) hit = 0;
					if (enable_mask[1] && !mid_bits[pm]) hit = 0;
					if (enable_mask[2] && !whole_bits[pw]) hit = 0;
					answers_due.push_back(hit);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %0b",
						$time, maybe_present);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (maybe_present !== want) begin
						$display("%0t: maybe_present mismatch, expected %0b, actual %0b",
							$time, want, maybe_present);
						errors++;
					end
				end
			end
			pending = answers_due.size();
		end
	end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the three-hash address filter: directed inserts and checks,
// then random mixes of inserts and re-checks of known and fresh addresses
// under several stage enable settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [2:0] ADDR_STAGE_ENABLE = 3'd0;
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam int CYCLE_LIMIT = 3000000;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic req_valid, req_stall, req_type;
	logic [63:0] addr;
	logic rsp_valid, rsp_stall, maybe_present;
	int errors, pending;
	int send_idle_pct, recv_stall_pct;
	int hold_cycles;
	int cycle_count;
	logic [63:0] inserted [$];

	three_hash_address_bloom_filter dut (.*);

	bloom_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_stall <= 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_enable(input logic [2:0] a, input logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_request(input logic t, input logic [63:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			@(posedge clk);
			req_valid <= 0;
		end
		@(posedge clk);
		req_valid <= 1; req_type <= t; addr <= a;
		do @(posedge clk); while (req_stall);
		req_valid <= 0;
		if (t == thab_pkg::REQ_INSERT) inserted.push_back(a);
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_addr;
		case ($urandom_range(3))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(255)) << ($urandom_range(63));
			2: return ~({$urandom, $urandom} & {$urandom, $urandom});
			default: return {32'h0, $urandom};
		endcase
	endfunction

	task automatic random_phase(input int n);
		logic [63:0] a;
		repeat (n) begin
			if ($urandom_range(1) && inserted.size() > 0) begin
				a = inserted[$urandom_range(inserted.size() - 1)];
				if ($urandom_range(3) == 0) a ^= 64'h1 << $urandom_range(63);
				send_request(thab_pkg::REQ_CHECK, a);
			end else begin
				send_request($urandom_range(1) ? thab_pkg::REQ_INSERT : thab_pkg::REQ_CHECK,
					rand_addr());
			end
		end
	endtask

	initial begin
		logic [2:0] masks [6];
		cycle_count = 0;
		hold_cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		req_valid = 0; req_type = 0; addr = 0; rsp_stall = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		send_request(thab_pkg::REQ_CHECK, 64'h0);
		send_request(thab_pkg::REQ_INSERT, 64'h0);
		send_request(thab_pkg::REQ_CHECK, 64'h0);
		send_request(thab_pkg::REQ_INSERT, '1);
		send_request(thab_pkg::REQ_CHECK, '1);
		send_request(thab_pkg::REQ_CHECK, 64'h8000_0000_0000_0000);
		send_request(thab_pkg::REQ_INSERT, 64'h0000_0000_ffff_ffff);
		send_request(thab_pkg::REQ_CHECK, 64'hffff_ffff_0000_0000);
		send_request(thab_pkg::REQ_CHECK, 64'h0000_0000_ffff_ffff);
		drain();
		write_enable(ADDR_STAGE_ENABLE, 32'h0);
		send_request(thab_pkg::REQ_CHECK, 64'h1234_5678_9abc_def0);
		send_request(thab_pkg::REQ_INSERT, 64'h1234_5678_9abc_def0);
		drain();
		write_enable(ADDR_STAGE_ENABLE, 32'hffff_fff9);
		write_enable(ADDR_UNUSED, 32'h0);
		send_request(thab_pkg::REQ_CHECK, 64'h1234_5678_0000_def0);
		send_request(thab_pkg::REQ_CHECK, 64'hffff_0000_9abc_0000);
		drain();

		masks = '{3'd7, 3'd1, 3'd2, 3'd4, 3'd0, 3'd7};
		for (int ph = 0; ph < 6; ph++) begin
			write_enable(ADDR_STAGE_ENABLE, {29'($urandom), masks[ph]});
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			if (ph == 2) hold_cycles = 600;
			random_phase(180);
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
